### sv/luhn_card_brand_check_assert.svh
// assertion macros used by the checker
`ifndef LUHN_CARD_BRAND_CHECK_ASSERT_SVH
`define LUHN_CARD_BRAND_CHECK_ASSERT_SVH

// checked only while out of reset
`define LCB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define LCB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/lcb_pkg.sv
package lcb_pkg;

    localparam int NUM_WIDTH  = 54;
    localparam int MAX_DIGITS = 16;
    // a 54-bit number has at most 17 decimal digits
    localparam int NUM_CELLS  = 17;

    localparam logic [1:0] BRAND_INVALID = 2'd0;
    localparam logic [1:0] BRAND_3X      = 2'd1;
    localparam logic [1:0] BRAND_5X      = 2'd2;
    localparam logic [1:0] BRAND_4X      = 2'd3;

    function automatic logic [63:0] pow10(input int e);
        logic [63:0] p;
        int          n;
        p = 64'd1;
        n = (e > 19) ? 19 : e;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    typedef struct packed {
        logic                 valid;
        logic                 in_range;
        logic [1:0]           brand;
        logic [3:0]           sum;
        logic [NUM_WIDTH-1:0] rem;
    } lcb_token_t;

endpackage

### sv/lcb_entry.sv
module lcb_entry (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            valid_i,
    input  logic [lcb_pkg::NUM_WIDTH-1:0]   num_i,
    output lcb_pkg::lcb_token_t             tok_o
);
    import lcb_pkg::*;

    localparam logic [63:0] LIMIT   = pow10(MAX_DIGITS) - 64'd1;
    localparam logic [63:0] P12     = pow10(12);
    localparam logic [63:0] P13     = pow10(13);
    localparam logic [63:0] P14     = pow10(14);
    localparam logic [63:0] P15     = pow10(15);
    localparam logic [63:0] R34_LO  = 64'd34 * P13;
    localparam logic [63:0] R34_HI  = 64'd35 * P13;
    localparam logic [63:0] R37_LO  = 64'd37 * P13;
    localparam logic [63:0] R37_HI  = 64'd38 * P13;
    localparam logic [63:0] R5X_LO  = 64'd51 * P14;
    localparam logic [63:0] R5X_HI  = 64'd56 * P14;
    localparam logic [63:0] R4S_LO  = 64'd4 * P12;
    localparam logic [63:0] R4S_HI  = 64'd5 * P12;
    localparam logic [63:0] R4L_LO  = 64'd4 * P15;
    localparam logic [63:0] R4L_HI  = 64'd5 * P15;

    logic [63:0] n64;
    logic        in_range;
    logic [1:0]  brand;
    logic        valid_reg;
    lcb_token_t  tok_reg;

    assign n64      = {{(64 - NUM_WIDTH){1'b0}}, num_i};
    assign in_range = (n64 <= LIMIT);

    always_comb begin
        priority if ((n64 >= R34_LO && n64 < R34_HI) || (n64 >= R37_LO && n64 < R37_HI)) begin
            brand = BRAND_3X;
        end else if (n64 >= R5X_LO && n64 < R5X_HI) begin
            brand = BRAND_5X;
        end else if ((n64 >= R4S_LO && n64 < R4S_HI) || (n64 >= R4L_LO && n64 < R4L_HI)) begin
            brand = BRAND_4X;
        end else begin
            brand = BRAND_INVALID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tok_reg.valid    <= 1'b0;
            tok_reg.in_range <= in_range;
            tok_reg.brand    <= brand;
            tok_reg.sum      <= 4'd0;
            tok_reg.rem      <= num_i;
        end
    end

    always_comb begin
        tok_o       = tok_reg;
        tok_o.valid = valid_reg;
    end

endmodule

### sv/lcb_cell.sv
module lcb_cell #(
    parameter int K = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  lcb_pkg::lcb_token_t tok_i,
    output lcb_pkg::lcb_token_t tok_o
);
    import lcb_pkg::*;

    localparam logic [63:0] PLACE  = pow10(K);
    // digit of this cell sits at an even position from the right
    localparam bit          DOUBLE = (K % 2) == 1;

    logic [63:0] rem64;
    logic [3:0]  digit;
    logic [63:0] sub;
    logic [4:0]  dbl;
    logic [3:0]  contrib;
    logic [4:0]  sum_add;
    logic [3:0]  sum_next;
    logic        valid_reg;
    lcb_token_t  tok_reg;

    assign rem64 = {{(64 - NUM_WIDTH){1'b0}}, tok_i.rem};

    always_comb begin
        digit = 4'd0;
        sub   = 64'd0;
        for (int m = 1; m <= 9; m++) begin
            if (rem64 >= 64'(m) * PLACE) begin
                digit = 4'(m);
                sub   = 64'(m) * PLACE;
            end
        end
    end

    assign dbl = {digit, 1'b0};

    always_comb begin
        if (DOUBLE) begin
            contrib = (dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0];
        end else begin
            contrib = digit;
        end
    end

    // running sum kept modulo ten
    assign sum_add  = {1'b0, tok_i.sum} + {1'b0, contrib};
    assign sum_next = (sum_add >= 5'd10) ? 4'(sum_add - 5'd10) : sum_add[3:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= tok_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tok_reg.valid    <= 1'b0;
            tok_reg.in_range <= tok_i.in_range;
            tok_reg.brand    <= tok_i.brand;
            tok_reg.sum      <= sum_next;
            tok_reg.rem      <= tok_i.rem - sub[NUM_WIDTH-1:0];
        end
    end

    always_comb begin
        tok_o       = tok_reg;
        tok_o.valid = valid_reg;
    end

endmodule

### sv/luhn_card_brand_check.sv
// channel   | dir | tdata                                       | notes
// s_        | in  | [53:0] card_number, [55:54] zero            | one number per item
// m_        | out | [0] checksum_ok, [2:1] brand, [7:3] zero    | one result per item
//
// entry register, 17 digit cells (one per decimal place,
// highest first), output register; one item per cycle when not stalled
// aresetn is synchronous, active low, and empties the pipeline
// a stall on m_tready holds the whole row of cells and drops s_tready
module luhn_card_brand_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // card_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // checksum_ok, brand
);
    import lcb_pkg::*;

    lcb_token_t tok [NUM_CELLS+1];
    logic       en;
    logic       m_tvalid_reg;
    logic       ok_reg;
    logic [1:0] brand_reg;
    logic       ok_next;
    logic [1:0] brand_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    lcb_entry u_entry (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (s_tvalid),
        .num_i   (s_tdata[NUM_WIDTH-1:0]),
        .tok_o   (tok[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        lcb_cell #(
            .K (NUM_CELLS - 1 - i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .tok_i   (tok[i]),
            .tok_o   (tok[i+1])
        );
    end

    assign ok_next    = tok[NUM_CELLS].in_range && (tok[NUM_CELLS].sum == 4'd0);
    assign brand_next = ok_next ? tok[NUM_CELLS].brand : BRAND_INVALID;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= tok[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok_reg    <= ok_next;
            brand_reg <= brand_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, brand_reg, ok_reg};

endmodule

### sv/lcb_checker.sv
module lcb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    import lcb_pkg::*;
`include "luhn_card_brand_check_assert.svh"

    logic stray_brand;
    logic m_stall;

    assign stray_brand = m_tvalid && !m_tdata[0] && (m_tdata[2:1] != BRAND_INVALID);
    assign m_stall     = m_tvalid && !m_tready;

    // a failed checksum never carries a brand
    `LCB_ASSERT(a_brand_needs_ok, aclk, aresetn, !stray_brand, "brand without checksum")

    // reset empties the output
    `LCB_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "item after reset")

    // the row of cells moves whenever the sink takes items
    `LCB_ASSERT(a_ready_follows, aclk, aresetn, m_tready |-> s_tready, "input held while sink ready")

    // held result stays put
    `LCB_ASSERT(a_hold_data, aclk, aresetn, m_stall |=> m_tvalid && $stable(m_tdata), "result moved")

endmodule

bind luhn_card_brand_check lcb_checker u_lcb_checker (.*);
